@@ rtl/ppa_pkg.sv @@
// ----------------------------------------------------------------------------
// ppa_pkg
// shared constants, types and pad mapping helpers for the pedestal accumulator
// ----------------------------------------------------------------------------
package ppa_pkg;

    localparam int CHAMBERS_DEF          = 7;
    localparam int ROWS_DEF              = 24;
    localparam int CHIPS_PER_ROW_DEF     = 10;
    localparam int CHANNELS_PER_CHIP_DEF = 48;
    localparam int COUNT_BITS_DEF        = 16;

    localparam int          Y_SPAN         = 48;
    localparam logic [15:0] EMPTY_MEAN_Q4  = 16'd64000;
    localparam logic [15:0] EMPTY_SIGMA_Q4 = 16'd16000;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    typedef struct packed {
        logic [15:0] mean_q4;
        logic [15:0] sigma_q4;
    } stats_result_t;

    // channel offset of a pad row within its group of six
    function automatic logic [2:0] y_to_addr(input logic [2:0] y_rem);
        logic [2:0] r;
        unique case (y_rem)
            3'd0:    r = 3'd5;
            3'd1:    r = 3'd3;
            3'd2:    r = 3'd1;
            3'd3:    r = 3'd0;
            3'd4:    r = 3'd2;
            3'd5:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/ppa_stats.sv @@
// ----------------------------------------------------------------------------
// ppa_stats
// sequential mean and sigma unit: shift-add products, digit square root and
// restoring division, one step per cycle
// ----------------------------------------------------------------------------
module ppa_stats #(
    parameter int COUNT_BITS = ppa_pkg::COUNT_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [COUNT_BITS-1:0]      cnt_in,
    input  logic [COUNT_BITS+11:0]     sum_in,
    input  logic [COUNT_BITS+23:0]     sq_in,
    output logic                       done,
    output ppa_pkg::stats_result_t     result
);

    localparam int CB  = COUNT_BITS;
    localparam int SW  = 12 + CB;
    localparam int PW  = 24 + 2 * CB;
    localparam int DW  = PW + 8;
    localparam int QW  = DW / 2;
    localparam int CTW = $clog2(QW + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MULA = 7'b0000010,
        S_MULB = 7'b0000100,
        S_DIFF = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_DIVS = 7'b0100000,
        S_DIVM = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CTW-1:0]   cnt_reg, cnt_next;
    logic [CB-1:0]    n_reg, n_next;
    logic [SW-1:0]    s_reg, s_next;
    logic [SW-1:0]    mplr_reg, mplr_next;
    logic [PW-1:0]    mcand_reg, mcand_next;
    logic [PW-1:0]    acc_reg, acc_next;
    logic [PW-1:0]    a_reg, a_next;
    logic [DW-1:0]    dsh_reg, dsh_next;
    logic [QW:0]      rem_reg, rem_next;
    logic [QW-1:0]    root_reg, root_next;
    logic [QW-1:0]    dvd_reg, dvd_next;
    logic [CB-1:0]    drem_reg, drem_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [15:0]      sigma_reg, sigma_next;
    logic [15:0]      mean_reg, mean_next;
    logic             done_reg, done_next;

    logic [PW-1:0]    mul_sum;
    logic [PW-1:0]    diff;
    logic [QW+2:0]    rem_sh, trial;
    logic             sq_ge;
    logic [CB:0]      div_try;
    logic             div_ge;
    logic [CB-1:0]    div_rem;
    logic [QW-1:0]    div_quo;

    assign mul_sum = acc_reg + (mplr_reg[0] ? mcand_reg : '0);
    assign diff    = (acc_reg >= a_reg) ? acc_reg - a_reg : a_reg - acc_reg;

    assign rem_sh = {rem_reg, dsh_reg[DW-1 -: 2]};
    assign trial  = (QW+3)'({root_reg, 2'b01});
    assign sq_ge  = rem_sh >= trial;

    assign div_try = {drem_reg, dvd_reg[QW-1]};
    assign div_ge  = div_try >= {1'b0, n_reg};
    assign div_rem = div_ge ? CB'(div_try - {1'b0, n_reg}) : CB'(div_try);
    assign div_quo = {quo_reg[QW-2:0], div_ge};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        s_next     = s_reg;
        mplr_next  = mplr_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        dsh_next   = dsh_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        dvd_next   = dvd_reg;
        drem_next  = drem_reg;
        quo_next   = quo_reg;
        sigma_next = sigma_reg;
        mean_next  = mean_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    n_next     = cnt_in;
                    s_next     = sum_in;
                    mplr_next  = SW'(cnt_in);
                    mcand_next = PW'(sq_in);
                    acc_next   = '0;
                    cnt_next   = CTW'(CB - 1);
                    state_next = S_MULA;
                end
            end
            S_MULA: begin
                acc_next   = mul_sum;
                mplr_next  = mplr_reg >> 1;
                mcand_next = mcand_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    a_next     = mul_sum;
                    acc_next   = '0;
                    mplr_next  = s_reg;
                    mcand_next = PW'(s_reg);
                    cnt_next   = CTW'(SW - 1);
                    state_next = S_MULB;
                end
            end
            S_MULB: begin
                acc_next   = mul_sum;
                mplr_next  = mplr_reg >> 1;
                mcand_next = mcand_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                dsh_next   = {diff, 8'b0};
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = CTW'(QW - 1);
                state_next = S_SQRT;
            end
            S_SQRT: begin
                rem_next  = sq_ge ? (QW+1)'(rem_sh - trial) : (QW+1)'(rem_sh);
                root_next = {root_reg[QW-2:0], sq_ge};
                dsh_next  = dsh_reg << 2;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    dvd_next   = {root_reg[QW-2:0], sq_ge};
                    drem_next  = '0;
                    quo_next   = '0;
                    cnt_next   = CTW'(QW - 1);
                    state_next = S_DIVS;
                end
            end
            S_DIVS: begin
                drem_next = div_rem;
                quo_next  = div_quo;
                dvd_next  = dvd_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    sigma_next = (|div_quo[QW-1:16]) ? 16'hFFFF : div_quo[15:0];
                    dvd_next   = QW'({s_reg, 4'b0});
                    drem_next  = '0;
                    quo_next   = '0;
                    cnt_next   = CTW'(QW - 1);
                    state_next = S_DIVM;
                end
            end
            S_DIVM: begin
                drem_next = div_rem;
                quo_next  = div_quo;
                dvd_next  = dvd_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    mean_next  = div_quo[15:0];
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        n_reg     <= n_next;
        s_reg     <= s_next;
        mplr_reg  <= mplr_next;
        mcand_reg <= mcand_next;
        acc_reg   <= acc_next;
        a_reg     <= a_next;
        dsh_reg   <= dsh_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        dvd_reg   <= dvd_next;
        drem_reg  <= drem_next;
        quo_reg   <= quo_next;
        sigma_reg <= sigma_next;
        mean_reg  <= mean_next;
    end

    assign done            = done_reg;
    assign result.mean_q4  = mean_reg;
    assign result.sigma_q4 = sigma_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == S_IDLE)
        else $error("start while busy");

    a_start_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> cnt_in != '0)
        else $error("start with empty pad");

    a_done_from_div: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(state_reg == S_DIVM))
        else $error("done outside the mean division");

endmodule

@@ rtl/pad_pedestal_accumulator.sv @@
// ----------------------------------------------------------------------------
// pad_pedestal_accumulator
// per-pad pedestal sums in one memory, with mean and sigma readout
// ----------------------------------------------------------------------------
// a sample transfer runs through decode, address, memory read and write back
// a readout runs through decode, address and memory read, then the stats unit's
//   shift-add, square root and two divisions, then the output register; a readout
//   of an empty or unmapped pad skips the stats unit
// one item in flight; the result sits in an output register while input resumes
// after aresetn the memory is swept one entry a cycle; s_ready stays low until
//   the sweep ends
module pad_pedestal_accumulator #(
    parameter int CHAMBERS          = ppa_pkg::CHAMBERS_DEF,
    parameter int ROWS              = ppa_pkg::ROWS_DEF,
    parameter int CHIPS_PER_ROW     = ppa_pkg::CHIPS_PER_ROW_DEF,
    parameter int CHANNELS_PER_CHIP = ppa_pkg::CHANNELS_PER_CHIP_DEF,
    parameter int COUNT_BITS        = ppa_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [2:0]  s_chamber,
    input  logic [2:0]  s_cathode,
    input  logic [6:0]  s_pad_x,
    input  logic [5:0]  s_pad_y,
    input  logic [11:0] s_charge,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_mean_q4,
    output logic [15:0] m_sigma_q4,
    output logic [21:0] m_threshold_word,
    output logic        m_pad_good,
    output logic        m_link_seen
);

    localparam int CB    = COUNT_BITS;
    localparam int SW    = 12 + CB;
    localparam int SQW   = 24 + CB;
    localparam int MW    = CB + SQW + SW;
    localparam int LINKS = 2 * CHAMBERS;
    localparam int PADS  = LINKS * ROWS * CHIPS_PER_ROW * CHANNELS_PER_CHIP;
    localparam int AW    = $clog2(PADS);
    localparam int LKW   = $clog2(LINKS);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [CB-1:0] COUNT_MAX = '1;

    typedef enum logic [6:0] {
        T_CLEAR = 7'b0000001,
        T_IDLE  = 7'b0000010,
        T_ADDR  = 7'b0000100,
        T_READ  = 7'b0001000,
        T_MOD   = 7'b0010000,
        T_CALC  = 7'b0100000,
        T_OUT   = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;

    // input decode
    logic [11:0]     y_prod;
    logic [3:0]      y_q;
    logic [5:0]      y_rem6;
    logic [5:0]      tmp;
    logic [5:0]      row_full;
    logic [3:0]      chip;
    logic [5:0]      chan;
    logic            dec_ok;

    logic            op_reg;
    logic [11:0]     q_reg;
    logic [23:0]     qsq_reg;
    logic            ok_reg;
    logic [LKW-1:0]  lk_reg;
    logic [RW-1:0]   row_reg;
    logic [3:0]      chip_reg;
    logic [5:0]      chan_reg;
    logic [AW-1:0]   pad_reg;
    logic [AW-1:0]   pad_calc;

    logic [LINKS-1:0] link_flags_reg, link_flags_next;
    logic            good_reg, good_next;
    logic            seen_reg, seen_next;

    // memory
    logic [MW-1:0]   mem [PADS];
    logic [MW-1:0]   mem_rdata_reg;
    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_waddr;
    logic [MW-1:0]   mem_wdata;
    logic [SW-1:0]   rd_sum;
    logic [SQW-1:0]  rd_sq;
    logic [CB-1:0]   rd_cnt;
    logic            upd;

    // stats
    logic                   stats_start;
    logic                   stats_done;
    ppa_pkg::stats_result_t stats_res;

    // output
    logic [15:0]     sel_mean, sel_sigma;
    logic [21:0]     sel_thr;
    logic [17:0]     thr_low;
    logic            m_valid_reg;
    logic [15:0]     m_mean_reg, m_sigma_reg;
    logic [21:0]     m_thr_reg;
    logic            m_good_reg, m_seen_reg;
    logic            out_load;

    assign y_prod   = 12'(s_pad_y) * 12'd43;
    assign y_q      = y_prod[11:8];
    assign y_rem6   = s_pad_y - 6'(y_q * 4'd6);
    assign tmp      = {1'b0, s_cathode[2:1], 3'b0} + 6'(y_q);
    assign row_full = s_cathode[0] ? tmp : 6'(ROWS - 1) - tmp;
    assign chip     = s_pad_x[6:3];
    assign chan     = 6'(ppa_pkg::y_to_addr(y_rem6[2:0])) + 6'(s_pad_x[2:0]) * 6'd6;
    assign dec_ok   = (32'(s_chamber) < CHAMBERS) && (32'(s_pad_y) < ppa_pkg::Y_SPAN)
                   && (32'(tmp) < ROWS) && (32'(chip) < CHIPS_PER_ROW)
                   && (32'(chan) < CHANNELS_PER_CHIP);

    assign pad_calc = ok_reg
        ? ((AW'(lk_reg) * AW'(ROWS) + AW'(row_reg)) * AW'(CHIPS_PER_ROW) + AW'(chip_reg))
          * AW'(CHANNELS_PER_CHIP) + AW'(chan_reg)
        : '0;

    assign rd_sum = mem_rdata_reg[SW-1:0];
    assign rd_sq  = mem_rdata_reg[SW+SQW-1:SW];
    assign rd_cnt = mem_rdata_reg[MW-1:SW+SQW];

    assign upd = (state_reg == T_MOD) && (op_reg == ppa_pkg::OP_SAMPLE) && ok_reg
              && (q_reg != '0);

    assign mem_we    = (state_reg == T_CLEAR) || (upd && (rd_cnt != COUNT_MAX));
    assign mem_re    = (state_reg == T_READ);
    assign mem_waddr = (state_reg == T_CLEAR) ? clr_reg : pad_reg;
    assign mem_wdata = (state_reg == T_CLEAR) ? '0
                     : {rd_cnt + 1'b1, rd_sq + SQW'(qsq_reg), rd_sum + SW'(q_reg)};

    assign stats_start = (state_reg == T_MOD) && (op_reg == ppa_pkg::OP_READOUT)
                      && ok_reg && (rd_cnt != '0);

    assign out_load = (state_reg == T_OUT) && (!m_valid_reg || m_ready);
    assign s_ready  = (state_reg == T_IDLE);

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        link_flags_next = link_flags_reg;
        good_next       = good_reg;
        seen_next       = seen_reg;
        unique case (state_reg)
            T_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(PADS - 1)) begin
                    state_next = T_IDLE;
                end
            end
            T_IDLE: begin
                if (s_valid) begin
                    state_next = T_ADDR;
                end
            end
            T_ADDR: begin
                state_next = T_READ;
            end
            T_READ: begin
                state_next = T_MOD;
            end
            T_MOD: begin
                if (op_reg == ppa_pkg::OP_SAMPLE) begin
                    if (upd) begin
                        link_flags_next[lk_reg] = 1'b1;
                    end
                    state_next = T_IDLE;
                end else begin
                    good_next  = stats_start;
                    seen_next  = ok_reg && link_flags_reg[lk_reg];
                    state_next = stats_start ? T_CALC : T_OUT;
                end
            end
            T_CALC: begin
                if (stats_done) begin
                    state_next = T_OUT;
                end
            end
            T_OUT: begin
                if (out_load) begin
                    state_next = T_IDLE;
                end
            end
            default: begin
                state_next = T_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_CLEAR;
            clr_reg        <= '0;
            link_flags_reg <= '0;
            good_reg       <= 1'b0;
            seen_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            link_flags_reg <= link_flags_next;
            good_reg       <= good_next;
            seen_reg       <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            q_reg    <= s_charge;
            ok_reg   <= dec_ok;
            lk_reg   <= LKW'({s_chamber, s_cathode[0]});
            row_reg  <= RW'(row_full);
            chip_reg <= chip;
            chan_reg <= chan;
        end
        if (state_reg == T_ADDR) begin
            pad_reg <= pad_calc;
            qsq_reg <= 24'(q_reg) * 24'(q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[pad_reg];
        end
    end

    ppa_stats #(
        .COUNT_BITS (COUNT_BITS)
    ) u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (stats_start),
        .cnt_in  (rd_cnt),
        .sum_in  (rd_sum),
        .sq_in   (rd_sq),
        .done    (stats_done),
        .result  (stats_res)
    );

    assign sel_mean  = good_reg ? stats_res.mean_q4 : ppa_pkg::EMPTY_MEAN_Q4;
    assign sel_sigma = good_reg ? stats_res.sigma_q4 : ppa_pkg::EMPTY_SIGMA_Q4;
    assign thr_low   = 18'(sel_mean) + 18'(sel_sigma) * 18'd3;
    assign sel_thr   = {1'b0, sel_mean[15:4], 9'b0} + 22'(thr_low[17:4]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_mean_reg  <= sel_mean;
            m_sigma_reg <= sel_sigma;
            m_thr_reg   <= sel_thr;
            m_good_reg  <= good_reg;
            m_seen_reg  <= seen_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_mean_q4        = m_mean_reg;
    assign m_sigma_q4       = m_sigma_reg;
    assign m_threshold_word = m_thr_reg;
    assign m_pad_good       = m_good_reg;
    assign m_link_seen      = m_seen_reg;

    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == T_CLEAR || state_reg == T_MOD))
        else $error("memory write outside clear or write back");

    a_in_to_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == T_ADDR)
        else $error("input transfer did not start decode");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == T_OUT))
        else $error("result raised outside output stage");

    a_good_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pad_good) |-> m_link_seen)
        else $error("good pad on an unseen link");

endmodule
